>>> design/ardse_pkg.sv
// shared types and constants for the ard squared-exponential kernel element
// no dependencies
`timescale 1ns / 1ps
package ardse_pkg;

  localparam int NUM_WEIGHTS = 6;
  localparam int SUM_W       = 40;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  // configuration register indexes
  localparam logic [3:0] CFG_SCALE = 4'd0;
  localparam logic [3:0] CFG_DIMS  = 4'd1;
  localparam logic [3:0] CFG_W0    = 4'd2;
  localparam logic [3:0] CFG_W1    = 4'd3;
  localparam logic [3:0] CFG_W2    = 4'd4;
  localparam logic [3:0] CFG_W3    = 4'd5;
  localparam logic [3:0] CFG_W4    = 4'd6;
  localparam logic [3:0] CFG_W5    = 4'd7;

  typedef struct packed {
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic               last_dim;
  } in_item_t;

  typedef struct packed {
    logic [31:0] kernel_value;
    logic        count_error;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [15:0] mag;
    logic        last;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t item;
  } q_head_t;

endpackage

>>> design/ardse_front.sv
// front part: accepts coordinate pairs, forms |x - y| and queues the request
// depends on ardse_pkg
`timescale 1ns / 1ps
module ardse_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  ardse_pkg::in_item_t in_data,
  output ardse_pkg::q_head_t head,
  input  logic               head_pop
);
  import ardse_pkg::*;

  work_t       ent_r [2];
  logic        wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic signed [16:0] diff;
  logic [16:0] mag;
  logic        do_push, do_pop;

  assign diff    = {in_data.x_coord[15], in_data.x_coord} -
                   {in_data.y_coord[15], in_data.y_coord};
  assign mag     = diff[16] ? 17'(-diff) : 17'(diff);
  assign in_full = (cnt_r == 2'd2);
  assign do_push = in_push && !in_full;
  assign do_pop  = head_pop && (cnt_r != 2'd0);

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = 2'(cnt_r + {1'b0, do_push} - {1'b0, do_pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r].mag  <= mag[15:0];
      ent_r[wr_ptr_r].last <= in_data.last_dim;
    end
  end

endmodule

>>> design/ardse_back.sv
// back part: accumulates the weighted distance and evaluates the exp table
// depends on ardse_pkg
`timescale 1ns / 1ps
module ardse_back #(
  parameter int MAX_DIMS        = 6,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ardse_pkg::q_head_t  head,
  output logic                head_pop,
  input  logic [15:0]         scale,
  input  logic [2:0]          dims_used,
  input  logic [15:0]         weight [ardse_pkg::NUM_WEIGHTS],
  output logic                out_empty,
  input  logic                out_pop,
  output ardse_pkg::out_item_t out_data
);
  import ardse_pkg::*;

  localparam int IW = $clog2(EXP_TABLE_DEPTH);
  localparam int DW = $clog2(EXP_TABLE_DEPTH + 1);

  typedef logic [15:0] tbl_t [EXP_TABLE_DEPTH];

  function automatic logic [63:0] power_q32(input logic [63:0] r);
    logic [63:0] a;
    a = 64'h1_0000_0000;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) a = (a * r) >> 32;
    return a;
  endfunction

  function automatic tbl_t build_tbl();
    tbl_t        t;
    logic [63:0] lo, hi, mid, a;
    lo = 64'h8000_0000;
    hi = 64'hFFFF_FFFF;
    a  = 64'h1_0000_0000;
    while (hi - lo > 64'd1) begin
      mid = lo + ((hi - lo) >> 1);
      if (power_q32(mid) >= 64'h8000_0000) hi = mid;
      else lo = mid;
    end
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      t[i] = 16'((a + 64'h1_0000) >> 17);
      a    = (a * hi + 64'h8000_0000) >> 32;
    end
    return t;
  endfunction

  localparam tbl_t EXP_TBL = build_tbl();

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_TERM = 4'd2;
  localparam logic [3:0] S_ACC  = 4'd3;
  localparam logic [3:0] S_EXP  = 4'd4;
  localparam logic [3:0] S_IDX  = 4'd5;
  localparam logic [3:0] S_TBL  = 4'd6;
  localparam logic [3:0] S_KMUL = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [2:0]       dim_r, dim_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [15:0]      mag_r;
  logic             last_r, err_r;
  logic [31:0]      sq_r, term_r, s2_r;
  logic [SUM_W-1:0] fin_r;
  logic [37:0]      u_r;
  logic             big_r, zero_r;
  logic [IW-1:0]    idx_r;
  logic [3:0]       n_r;
  logic [15:0]      expv_r;
  logic [47:0]      kp_r, kr;
  logic             out_valid_r;
  out_item_t        out_r;
  logic [15:0]      wsel;
  logic [2:0]       cnt;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_sat;
  logic [32+DW-1:0] fprod;
  logic             out_free;

  assign wsel = (32'(dim_r) < MAX_DIMS && 32'(dim_r) < NUM_WEIGHTS) ? weight[dim_r] : 16'd0;
  assign cnt  = (dim_r == 3'd7) ? 3'd7 : 3'(dim_r + 3'd1);
  assign sum_add = {1'b0, sum_r} + {9'd0, term_r};
  assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  assign fprod   = u_r[31:0] * DW'(EXP_TABLE_DEPTH);
  assign out_free  = !out_valid_r || out_pop;
  assign head_pop  = (state_r == S_IDLE) && head.valid;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;
  assign kr        = kp_r + 48'h4000;

  always_comb begin
    state_nxt = state_r;
    dim_nxt   = dim_r;
    sum_nxt   = sum_r;
    unique case (state_r)
      S_IDLE: if (head.valid) state_nxt = S_SQ;
      S_SQ:   state_nxt = S_TERM;
      S_TERM: state_nxt = S_ACC;
      S_ACC: begin
        if (last_r) begin
          sum_nxt   = '0;
          dim_nxt   = 3'd0;
          state_nxt = S_EXP;
        end else begin
          sum_nxt   = sum_sat;
          dim_nxt   = cnt;
          state_nxt = S_IDLE;
        end
      end
      S_EXP:  state_nxt = S_IDX;
      S_IDX:  state_nxt = S_TBL;
      S_TBL:  state_nxt = S_KMUL;
      S_KMUL: state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dim_r       <= 3'd0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dim_r   <= dim_nxt;
      sum_r   <= sum_nxt;
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      mag_r  <= head.item.mag;
      last_r <= head.item.last;
    end
    sq_r   <= mag_r * mag_r;
    term_r <= 32'((48'(sq_r) * 48'(wsel)) >> 16);
    if (state_r == S_ACC) begin
      fin_r <= sum_sat;
      err_r <= (cnt != dims_used) || (32'(cnt) > MAX_DIMS);
    end
    u_r    <= 38'(fin_r[20:0]) * 38'(LOG2E_Q16);
    big_r  <= (fin_r >= SUM_W'(64'h20_0000));
    s2_r   <= scale * scale;
    idx_r  <= fprod[32 +: IW];
    zero_r <= big_r || (u_r[37:32] >= 6'd16);
    n_r    <= u_r[35:32];
    expv_r <= zero_r ? 16'd0 : (EXP_TBL[idx_r] >> n_r);
    kp_r   <= 48'(s2_r) * 48'(expv_r);
    if (state_r == S_OUT && out_free) begin
      out_r.kernel_value <= kr[46:15];
      out_r.count_error  <= err_r;
    end
  end

endmodule

>>> design/ard_se_kernel_element.sv
// Top level of the ard squared-exponential kernel element.
// Input queue: push one coordinate pair per request while full is low;
// last_dim marks the final dimension of a point pair. Result queue: while
// out_empty is low the kernel value (unsigned Q16.16) and the dimension
// count flag are on out_data; pop takes it.
// Configuration: cfg_valid/cfg_ready with a register index and data;
// ready is always high, writes beyond index 7 are dropped. Write only idle.
// Timing: the front holds two requests. The back sequencer steps through
// square, weight and accumulate on each dimension, and on the last one
// through log2 scaling, table index, table and shift, amplitude multiply
// and output. The back stalls in its output step while the result slot is
// occupied; the front keeps accepting until its two entries are full.
// Reset clears the sum, dimension count, queues and restores register
// defaults; no clearing pass is needed.
// depends on ardse_pkg, ardse_front, ardse_back
`timescale 1ns / 1ps
module ard_se_kernel_element #(
  parameter int MAX_DIMS        = 6,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  ardse_pkg::in_item_t  in_data,
  output logic                 out_empty,
  input  logic                 out_pop,
  output ardse_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [3:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import ardse_pkg::*;

  logic [15:0] scale_r;
  logic [2:0]  dims_r;
  logic [15:0] weight_r [NUM_WEIGHTS];
  q_head_t     head;
  logic        head_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 16'd256;
      dims_r  <= 3'd1;
      for (int i = 0; i < NUM_WEIGHTS; i++) weight_r[i] <= 16'd32768;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SCALE: scale_r <= cfg_data;
        CFG_DIMS:  dims_r  <= cfg_data[2:0];
        CFG_W0, CFG_W1, CFG_W2, CFG_W3, CFG_W4, CFG_W5:
          weight_r[3'(cfg_index - CFG_W0)] <= cfg_data;
        default: ;
      endcase
    end
  end

  ardse_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .head     (head),
    .head_pop (head_pop)
  );

  ardse_back #(
    .MAX_DIMS        (MAX_DIMS),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_pop  (head_pop),
    .scale     (scale_r),
    .dims_used (dims_r),
    .weight    (weight_r),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

>>> bench/tb.sv
// self-checking bench for ard_se_kernel_element: queued stimulus, clocked driver and monitor
// kernel values predicted with an exp table rebuilt here; depends on ardse_pkg
`timescale 1ns / 1ps
module tb;
  import ardse_pkg::*;

  localparam int PAIR_LIMIT = 8;     // dims sent per pair at most, beyond the counter limit
  localparam int SETTLE     = 80;    // cycles for the back end to drain
  localparam int STALL_MAX  = 6000;  // cycles without any handshake
  localparam logic [3:0] CFG_UNUSED = 4'd11;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_item_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  ard_se_kernel_element uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  in_item_t  coord_q[$];
  out_item_t kernel_q[$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;

  // predictor state and register copies
  logic [15:0] amp_r;
  logic [2:0]  dims_r;
  logic [15:0] wt_r[NUM_WEIGHTS];
  logic [2:0]  dim_cnt;
  logic [39:0] dist_sum;
  logic [15:0] exp_lut[256];

  function automatic logic [63:0] pow_q32(logic [63:0] r);
    logic [127:0] a;
    a = 128'd1 << 32;
    for (int i = 0; i < 256; i++) a = (a * r) >> 32;
    return a[63:0];
  endfunction

  task automatic build_exp_lut();
    logic [63:0] lo, hi, mid;
    logic [127:0] a;
    lo = 64'd1 << 31;
    hi = (64'd1 << 32) - 1;
    while (hi - lo > 1) begin
      mid = lo + ((hi - lo) >> 1);
      if (pow_q32(mid) >= (64'd1 << 31)) hi = mid;
      else lo = mid;
    end
    a = 128'd1 << 32;
    for (int i = 0; i < 256; i++) begin
      exp_lut[i] = 16'((a + (128'd1 << 16)) >> 17);
      a = (a * hi + (128'd1 << 31)) >> 32;
    end
  endtask

  function automatic logic [15:0] exp_q15(logic [39:0] s);
    logic [63:0] u;
    if (s >= (40'd1 << 21)) return '0;
    u = 64'(s) * 64'(LOG2E_Q16);
    if (u[63:32] >= 16) return '0;
    return exp_lut[u[31:24]] >> u[63:32];
  endfunction

  task automatic accumulate_coord(in_item_t it);
    logic signed [16:0] d;
    logic [16:0] mag;
    logic [33:0] sq;
    logic [63:0] term;
    logic [40:0] nsum;
    logic [15:0] w;
    logic [2:0] cnt;
    logic [63:0] k;
    out_item_t r;
    d = 17'(it.x_coord) - 17'(it.y_coord);
    mag = d[16] ? 17'(-d) : 17'(d);
    sq = 34'(mag) * 34'(mag);
    w = (dim_cnt < NUM_WEIGHTS) ? wt_r[dim_cnt] : '0;
    term = (64'(sq) * 64'(w)) >> 16;
    nsum = 41'(dist_sum) + 41'(term);
    if (nsum[40]) nsum = {1'b0, {40{1'b1}}};
    cnt = (dim_cnt < 7) ? dim_cnt + 3'd1 : 3'd7;
    if (!it.last_dim) begin
      dist_sum = nsum[39:0];
      dim_cnt = cnt;
    end else begin
      k = ((64'(amp_r) * 64'(amp_r)) * 64'(exp_q15(nsum[39:0])) + (64'd1 << 14)) >> 15;
      r.kernel_value = k[31:0];
      r.count_error = (cnt != dims_r) || (cnt > NUM_WEIGHTS);
      kernel_q.push_back(r);
      dist_sum = '0;
      dim_cnt = '0;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!(in_push && in_full)) begin
      if (in_push) begin
        accumulate_coord(coord_q[0]);
        void'(coord_q.pop_front());
      end
      if (coord_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_push <= 1'b1;
        in_data <= coord_q[0];
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (kernel_q.size() == 0) begin
        $error("result with none expected: kernel_value %0h", out_data.kernel_value);
        errors++;
      end else begin
        if (out_data.kernel_value !== kernel_q[0].kernel_value) begin
          $error("kernel_value expected %0h actual %0h",
                 kernel_q[0].kernel_value, out_data.kernel_value);
          errors++;
        end
        if (out_data.count_error !== kernel_q[0].count_error) begin
          $error("count_error expected %0b actual %0b",
                 kernel_q[0].count_error, out_data.count_error);
          errors++;
        end
        void'(kernel_q.pop_front());
      end
    end
    out_pop <= rst_n && ($urandom_range(99) >= recv_stall);
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic add_coord(logic [15:0] x, logic [15:0] y, logic last);
    in_item_t it;
    it.x_coord = x;
    it.y_coord = y;
    it.last_dim = last;
    coord_q.push_back(it);
  endtask

  // one point pair, mostly close points so the exp stays above zero
  task automatic add_pair(int n);
    logic [15:0] x, y;
    for (int i = 0; i < n; i++) begin
      x = 16'($urandom);
      case ($urandom_range(3))
        0: y = 16'($urandom);
        1: y = x + 16'($urandom_range(64)) - 16'd32;
        default: y = x + 16'($urandom_range(1024)) - 16'd512;
      endcase
      add_coord(x, y, i == n - 1);
    end
  endtask

  task automatic write_reg(logic [3:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SCALE: amp_r = val;
      CFG_DIMS:  dims_r = val[2:0];
      CFG_W0, CFG_W1, CFG_W2, CFG_W3, CFG_W4, CFG_W5: wt_r[idx - CFG_W0] = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (coord_q.size() > 0 || in_push || kernel_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_regs();
    write_reg(CFG_SCALE, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1024)));
    write_reg(CFG_DIMS, 16'($urandom_range(1, NUM_WEIGHTS)));
    for (int i = 0; i < NUM_WEIGHTS; i++)
      write_reg(CFG_W0 + 4'(i), ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40000)));
  endtask

  task automatic run_pairs(int pairs, int idle_pct, int stall_pct);
    for (int p = 0; p < pairs; p++)
      add_pair(($urandom_range(5) == 0) ? $urandom_range(1, PAIR_LIMIT) : int'(dims_r));
    send_idle = idle_pct;
    recv_stall = stall_pct;
    wait_idle();
  endtask

  initial begin
    build_exp_lut();
    amp_r = 16'd256;
    dims_r = 3'd1;
    for (int i = 0; i < NUM_WEIGHTS; i++) wt_r[i] = 16'd32768;
    dim_cnt = '0;
    dist_sum = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, coordinate extremes, zero distance
    add_coord(16'h0000, 16'h0000, 1'b1);
    add_coord(16'h7fff, 16'h8000, 1'b1);
    add_coord(16'h8000, 16'h7fff, 1'b1);
    add_coord(16'hffff, 16'h0000, 1'b1);
    add_coord(16'h0100, 16'h0000, 1'b1);
    // dimension count too long, counter saturation with zero weights
    add_coord(16'h0010, 16'h0000, 1'b0);
    add_coord(16'h0000, 16'h0020, 1'b1);
    for (int i = 0; i < PAIR_LIMIT; i++) add_coord(16'h0040, 16'h0000, i == PAIR_LIMIT - 1);
    wait_idle();

    // largest amplitude and weights, all six dims
    write_reg(CFG_SCALE, 16'hffff);
    write_reg(CFG_DIMS, 16'd6);
    for (int i = 0; i < NUM_WEIGHTS; i++) write_reg(CFG_W0 + 4'(i), 16'hffff);
    write_reg(CFG_UNUSED, 16'h1234);
    for (int i = 0; i < 6; i++) add_coord(16'h0000, 16'h0000, i == 5);
    for (int i = 0; i < 6; i++) add_coord(16'h0030, 16'hffe0, i == 5);
    for (int i = 0; i < 6; i++) add_coord(16'h8000, 16'h7fff, i == 5);
    wait_idle();

    // zero amplitude and weights, dims_used out of range both ways
    write_reg(CFG_SCALE, 16'h0000);
    for (int i = 0; i < NUM_WEIGHTS; i++) write_reg(CFG_W0 + 4'(i), 16'h0000);
    write_reg(CFG_DIMS, 16'd0);
    add_coord(16'h1234, 16'h4321, 1'b1);
    wait_idle();
    write_reg(CFG_SCALE, 16'h0100);
    write_reg(CFG_DIMS, 16'd7);
    for (int i = 0; i < 7; i++) add_coord(16'h7fff, 16'h8000, i == 6);
    wait_idle();

    // random pairs across stall patterns and register settings
    random_regs();
    run_pairs(25, 0, 0);
    random_regs();
    run_pairs(20, 85, 0);
    random_regs();
    run_pairs(20, 0, 85);
    random_regs();
    run_pairs(30, 12, 12);
    random_regs();
    run_pairs(25, 0, 0);
    random_regs();
    run_pairs(25, 12, 12);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
